>>> rtl/core/rosm_pkg.sv
// Package with the types, constants and helpers of the room occupancy state machine.
`default_nettype none

package rosm_pkg;

    localparam int TIME_BITS     = 32;
    localparam int CMP_BITS      = (TIME_BITS > 24) ? TIME_BITS : 24;
    localparam int RANGE_BITS    = 12;
    localparam int STAMP_BITS    = 32;
    localparam int COUNT_BITS    = 8;
    localparam int OCC_BITS      = 32;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 24;
    localparam int S_TDATA_BITS  = 48;
    localparam int M_TDATA_BITS  = 48;

    localparam logic [CFG_IDX_BITS-1:0] REG_MOVE_THRESH   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STILL_AFTER   = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMPTY_TIMEOUT = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_PERIOD = 8'd3;

    localparam logic [11:0] RST_MOVE_THRESH   = 12'd50;
    localparam logic [15:0] RST_STILL_AFTER   = 16'd5000;
    localparam logic [23:0] RST_EMPTY_TIMEOUT = 24'd60000;
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd100;

    localparam logic [1:0] CODE_EMPTY    = 2'd0;
    localparam logic [1:0] CODE_OCCUPIED = 2'd1;
    localparam logic [1:0] CODE_MOTION   = 2'd2;
    localparam logic [1:0] CODE_STILL    = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [OCC_BITS-1:0]   OCC_MAX   = '1;

    typedef enum logic [3:0] {
        MODE_EMPTY    = 4'b0001,
        MODE_OCCUPIED = 4'b0010,
        MODE_MOTION   = 4'b0100,
        MODE_STILL    = 4'b1000
    } mode_t;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [11:0] move_thresh;
        logic [15:0] still_after_ms;
        logic [23:0] empty_timeout_ms;
        logic [15:0] sample_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [STAMP_BITS-1:0] timestamp_ms;
        logic [RANGE_BITS-1:0] range_value;
        logic                  range_valid;
        logic                  presence;
    } item_t;

    typedef struct packed {
        logic                  relay_on;
        logic                  led_on;
        logic [OCC_BITS-1:0]   occupied_ms;
        logic [COUNT_BITS-1:0] people_count;
        logic                  mode_changed;
        logic [1:0]            room_mode;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t mode);
        logic [1:0] code;
        unique case (mode)
            MODE_EMPTY:    code = CODE_EMPTY;
            MODE_OCCUPIED: code = CODE_OCCUPIED;
            MODE_MOTION:   code = CODE_MOTION;
            MODE_STILL:    code = CODE_STILL;
            default:       code = CODE_EMPTY;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/rosm_cfg.sv
// Configuration register file with its write channel.
`default_nettype none

module rosm_cfg
    import rosm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MOVE_THRESH:   cfg_next.move_thresh      = cfg_data[11:0];
                REG_STILL_AFTER:   cfg_next.still_after_ms   = cfg_data[15:0];
                REG_EMPTY_TIMEOUT: cfg_next.empty_timeout_ms = cfg_data[23:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period_ms = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.move_thresh      <= RST_MOVE_THRESH;
            cfg_reg.still_after_ms   <= RST_STILL_AFTER;
            cfg_reg.empty_timeout_ms <= RST_EMPTY_TIMEOUT;
            cfg_reg.sample_period_ms <= RST_SAMPLE_PERIOD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/rosm_update.sv
// Room state registers and the single-pass update that turns one reading into one result.
`default_nettype none

module rosm_update
    import rosm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    mode_t                 mode_reg, mode_next;
    logic [RANGE_BITS-1:0] prev_range_reg, prev_range_next;
    logic                  prev_ok_reg, prev_ok_next;
    time_t                 last_act_reg, last_act_next;
    time_t                 last_motion_reg, last_motion_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic                  relay_reg, relay_next;

    time_t                 now;
    logic [RANGE_BITS-1:0] diff;
    logic                  motion;
    time_t                 since_motion;
    time_t                 since_act;
    logic [OCC_BITS-1:0]   occ_base;
    logic [OCC_BITS:0]     occ_sum;
    logic                  changed;

    always_comb begin
        now  = TIME_BITS'(item.timestamp_ms);
        diff = (item.range_value > prev_range_reg) ? item.range_value - prev_range_reg
                                                    : prev_range_reg - item.range_value;
        motion = item.range_valid && (item.range_value != '0) && prev_ok_reg &&
                 (prev_range_reg != '0) && (diff > cfg.move_thresh);

        mode_next        = mode_reg;
        count_next       = count_reg;
        occ_next         = occ_reg;
        last_motion_next = motion ? now : last_motion_reg;
        last_act_next    = motion ? now : last_act_reg;
        prev_range_next  = item.range_valid ? item.range_value : '0;
        prev_ok_next     = item.range_valid;
        occ_base         = occ_reg;
        occ_sum          = '0;
        since_motion     = '0;
        since_act        = now - last_act_next;

        if (item.presence) begin
            last_act_next = now;
            if (mode_reg == MODE_EMPTY) begin
                mode_next        = MODE_OCCUPIED;
                occ_base         = '0;
                last_motion_next = now;
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + 1'b1;
                end
            end
            since_motion = now - last_motion_next;
            if (motion) begin
                mode_next = MODE_MOTION;
            end else if (CMP_BITS'(since_motion) > CMP_BITS'(cfg.still_after_ms)) begin
                mode_next = MODE_STILL;
            end
            occ_sum  = {1'b0, occ_base} + (OCC_BITS + 1)'(cfg.sample_period_ms);
            occ_next = occ_sum[OCC_BITS] ? OCC_MAX : occ_sum[OCC_BITS-1:0];
        end else if ((CMP_BITS'(since_act) > CMP_BITS'(cfg.empty_timeout_ms)) &&
                     (mode_reg != MODE_EMPTY)) begin
            mode_next = MODE_EMPTY;
            occ_next  = '0;
            if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
            end
        end

        changed    = (mode_next != mode_reg);
        relay_next = relay_reg;
        if (changed) begin
            if (mode_next == MODE_EMPTY) begin
                relay_next = 1'b0;
            end else if (mode_next != MODE_STILL) begin
                relay_next = 1'b1;
            end
        end

        result.room_mode    = mode_code(mode_next);
        result.mode_changed = changed;
        result.people_count = count_next;
        result.occupied_ms  = occ_next;
        result.led_on       = (mode_next != MODE_EMPTY);
        result.relay_on     = relay_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_EMPTY;
            prev_range_reg  <= '0;
            prev_ok_reg     <= 1'b0;
            last_act_reg    <= '0;
            last_motion_reg <= '0;
            count_reg       <= '0;
            occ_reg         <= '0;
            relay_reg       <= 1'b0;
        end else if (step) begin
            mode_reg        <= mode_next;
            prev_range_reg  <= prev_range_next;
            prev_ok_reg     <= prev_ok_next;
            last_act_reg    <= last_act_next;
            last_motion_reg <= last_motion_next;
            count_reg       <= count_next;
            occ_reg         <= occ_next;
            relay_reg       <= relay_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/room_occupancy_state_machine_unit.sv
// Top level of the room occupancy state machine: stream channels, input and result registers.
//
// Each transaction on the s_ channel is one parsed presence-radar reading; each
// reading gives exactly one result transaction on the m_ channel carrying the
// room mode, the mode-change flag, the people count, the occupied time and the
// LED and relay levels. The cfg_ channel writes the four configuration
// registers by index; it is always ready and should be used while the block is
// idle. Indexes beyond the register list are ignored.
// A reading is captured in an input register, the room state is updated in one
// pass of compare and add logic, and the result is registered: a reading passes
// through the input register and then the result register before m_tvalid rises.
// One reading is taken every cycle as long as the result side keeps up; the rate
// is set by the state update loop. When m_tready is low the result register
// holds, the input register fills, and s_tready then drops until the result is
// taken. Reset clears the valid flags of both registers and the room state
// (empty, count and time zero, relay off) and restores the configuration
// defaults.
`default_nettype none

module room_occupancy_state_machine_unit
    import rosm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // presence, range_valid, range_value[11:0], timestamp_ms[31:0], zero fill
    input  wire logic [S_TDATA_BITS-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // room_mode[1:0], mode_changed, people_count[7:0], occupied_ms[31:0],
    // led_on, relay_on, zero fill
    output logic [M_TDATA_BITS-1:0]       m_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;

    cfg_t    cfg;
    result_t result;
    logic    step;
    logic    take;

    rosm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rosm_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_BITS'(out_result_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg <= s_tdata[$bits(item_t)-1:0];
        end
        if (step) begin
            out_result_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_room_occupancy_state_machine_unit.sv
// Testbench for the room occupancy state machine unit with a behavioral predictor.
`timescale 1ns / 100ps

module tb_room_occupancy_state_machine_unit;
    import rosm_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = 8'd4;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    room_occupancy_state_machine_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [11:0] thr_cfg;
    logic [15:0] still_cfg;
    logic [23:0] empty_cfg;
    logic [15:0] period_cfg;

    logic [1:0]            cur_mode;
    logic [RANGE_BITS-1:0] last_range;
    logic                  last_range_ok;
    logic [31:0]           activity_stamp;
    logic [31:0]           motion_stamp;
    logic [COUNT_BITS-1:0] occupants;
    logic [OCC_BITS-1:0]   occupied_time;
    logic                  relay_state;

    item_t   pending_readings[$];
    result_t expected_results[$];

    int          mismatch_count = 0;
    int          s_idle_pct = 0;
    int          m_idle_pct = 0;
    int          hold_left = 0;
    bit          hold_kick = 0;
    bit          s_taken = 0;
    logic [31:0] stim_clock;
    logic [11:0] stim_range;
    bit          visiting;

    task automatic reset_room_model;
        thr_cfg        = RST_MOVE_THRESH;
        still_cfg      = RST_STILL_AFTER;
        empty_cfg      = RST_EMPTY_TIMEOUT;
        period_cfg     = RST_SAMPLE_PERIOD;
        cur_mode       = CODE_EMPTY;
        last_range     = '0;
        last_range_ok  = 1'b0;
        activity_stamp = '0;
        motion_stamp   = '0;
        occupants      = '0;
        occupied_time  = '0;
        relay_state    = 1'b0;
    endtask

    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_MOVE_THRESH:   thr_cfg = val[11:0];
            REG_STILL_AFTER:   still_cfg = val[15:0];
            REG_EMPTY_TIMEOUT: empty_cfg = val[23:0];
            REG_SAMPLE_PERIOD: period_cfg = val[15:0];
            default: ;
        endcase
    endfunction

    function automatic result_t predict_room_update(input item_t rd);
        result_t     res;
        logic [1:0]  prior;
        logic        moved;
        logic [11:0] gap;
        logic [31:0] now;
        logic [31:0] elapsed;
        now   = rd.timestamp_ms;
        prior = cur_mode;
        moved = 1'b0;
        if (rd.range_valid && rd.range_value != '0 && last_range_ok && last_range != '0) begin
            gap = (rd.range_value > last_range) ? rd.range_value - last_range
                                                : last_range - rd.range_value;
            if (gap > thr_cfg) begin
                moved          = 1'b1;
                motion_stamp   = now;
                activity_stamp = now;
            end
        end
        last_range    = rd.range_valid ? rd.range_value : '0;
        last_range_ok = rd.range_valid;
        if (rd.presence) begin
            activity_stamp = now;
            if (prior == CODE_EMPTY) begin
                cur_mode      = CODE_OCCUPIED;
                occupied_time = '0;
                if (occupants != COUNT_MAX) occupants = occupants + 1'b1;
                motion_stamp = now;
            end
            elapsed = now - motion_stamp;
            if (moved) begin
                cur_mode = CODE_MOTION;
            end else if (elapsed > {16'd0, still_cfg}) begin
                cur_mode = CODE_STILL;
            end
            if (occupied_time > OCC_MAX - {16'd0, period_cfg}) occupied_time = OCC_MAX;
            else occupied_time = occupied_time + {16'd0, period_cfg};
        end else begin
            elapsed = now - activity_stamp;
            if (elapsed > {8'd0, empty_cfg} && prior != CODE_EMPTY) begin
                cur_mode      = CODE_EMPTY;
                occupied_time = '0;
                if (occupants != '0) occupants = occupants - 1'b1;
            end
        end
        if (cur_mode != prior) begin
            if (cur_mode == CODE_EMPTY) relay_state = 1'b0;
            else if (cur_mode != CODE_STILL) relay_state = 1'b1;
        end
        res.room_mode    = cur_mode;
        res.mode_changed = (cur_mode != prior);
        res.people_count = occupants;
        res.occupied_ms  = occupied_time;
        res.led_on       = (cur_mode != CODE_EMPTY);
        res.relay_on     = relay_state;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    // Both transactions of a clock edge are seen here; results are checked in order.
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        item_t   seen;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen = s_tdata[$bits(item_t)-1:0];
                expected_results.push_back(predict_room_update(seen));
                s_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result expected none actual %0h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    check_field("room_mode", 32'(want.room_mode), 32'(got.room_mode));
                    check_field("mode_changed", 32'(want.mode_changed),
                                32'(got.mode_changed));
                    check_field("people_count", 32'(want.people_count),
                                32'(got.people_count));
                    check_field("occupied_ms", want.occupied_ms, got.occupied_ms);
                    check_field("led_on", 32'(want.led_on), 32'(got.led_on));
                    check_field("relay_on", 32'(want.relay_on), 32'(got.relay_on));
                end
            end
        end
    end

    always @(negedge aclk) begin
        item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= s_idle_pct) begin
                nxt = pending_readings.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_TDATA_BITS - $bits(item_t)){1'b0}}, nxt};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        s_taken = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= m_idle_pct);
    end

    always @(negedge aclk) begin
        if (hold_kick) begin
            hold_left <= 150;
            hold_kick = 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic queue_reading(input logic pres, input logic rv, input logic [11:0] rng,
                                 input logic [31:0] stamp);
        item_t it;
        it.presence     = pres;
        it.range_valid  = rv;
        it.range_value  = rng;
        it.timestamp_ms = stamp;
        pending_readings.push_back(it);
    endtask

    // Visits: mostly present readings while someone is in, mostly absent ones otherwise.
    task automatic queue_visits(input int count);
        int          pick;
        int          v;
        logic [31:0] step;
        logic        pres;
        logic        rv;
        logic [11:0] rng;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) step = $urandom_range(300, 1);
            else if (pick < 75) step = $urandom_range(2 * still_cfg + 2, 0);
            else if (pick < 92) step = $urandom_range(2 * empty_cfg + 2, 0);
            else step = $urandom;
            stim_clock = stim_clock + step;
            if ($urandom_range(11) == 0) visiting = !visiting;
            pres = visiting ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
            rv   = ($urandom_range(3) != 0);
            pick = $urandom_range(7);
            if (pick == 0) begin
                rng = '0;
            end else if (pick == 1) begin
                rng = 12'($urandom_range(4095));
            end else begin
                v = int'(stim_range) + int'($urandom_range(2 * thr_cfg + 2)) - int'(thr_cfg) - 1;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                rng = v[11:0];
            end
            if (rv) stim_range = rng;
            queue_reading(pres, rv, rng, stim_clock);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_register(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        do @(negedge aclk);
        while (pending_readings.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_idling(input int s_pct, input int m_pct);
        @(posedge aclk);
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        stim_clock = 32'd1000;
        stim_range = 12'd100;
        visiting   = 1'b0;
        reset_room_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(17, 63);
        @(posedge aclk);
        queue_reading(1'b0, 1'b0, 12'd0,    32'd1000);
        queue_reading(1'b0, 1'b1, 12'd100,  32'd1500);
        queue_reading(1'b0, 1'b1, 12'd300,  32'd1600);
        queue_reading(1'b1, 1'b1, 12'd300,  32'd2000);
        queue_reading(1'b1, 1'b1, 12'd351,  32'd2100);
        queue_reading(1'b1, 1'b1, 12'd401,  32'd2200);
        queue_reading(1'b1, 1'b1, 12'd4095, 32'd2300);
        queue_reading(1'b1, 1'b1, 12'd0,    32'd2400);
        queue_reading(1'b1, 1'b1, 12'd2000, 32'd2500);
        queue_reading(1'b1, 1'b0, 12'd4095, 32'd7500);
        queue_reading(1'b1, 1'b1, 12'd2000, 32'd7600);
        queue_reading(1'b1, 1'b1, 12'd3000, 32'd7700);
        queue_reading(1'b0, 1'b0, 12'd0,    32'd67700);
        queue_reading(1'b0, 1'b0, 12'd0,    32'd67701);
        queue_reading(1'b0, 1'b0, 12'd0,    32'd200000);
        queue_reading(1'b1, 1'b1, 12'd10,   32'hFFFF_FF00);
        queue_reading(1'b1, 1'b1, 12'd10,   32'h0000_1400);
        queue_reading(1'b0, 1'b1, 12'd4095, 32'h0000_2000);
        queue_reading(1'b0, 1'b0, 12'd0,    32'h0000_2000 + 32'd60001);
        queue_reading(1'b1, 1'b0, 12'd0,    32'hFFFF_FFFF);
        queue_reading(1'b0, 1'b0, 12'd0,    32'd60000);
        wait_drained();

        write_register(REG_MOVE_THRESH, 24'd0);
        write_register(REG_STILL_AFTER, 24'd0);
        write_register(REG_EMPTY_TIMEOUT, 24'd0);
        write_register(REG_SAMPLE_PERIOD, 24'd0);
        @(posedge aclk);
        queue_visits(230);
        hold_kick = 1'b1;
        wait_drained();

        set_idling(63, 17);
        write_register(REG_MOVE_THRESH, 24'd4095);
        write_register(REG_STILL_AFTER, 24'd65535);
        write_register(REG_EMPTY_TIMEOUT, 24'd16777215);
        write_register(REG_SAMPLE_PERIOD, 24'd1);
        @(posedge aclk);
        queue_visits(230);
        wait_drained();

        set_idling(0, 0);
        write_register(REG_MOVE_THRESH, 24'($urandom_range(24'hFFFFFF)));
        write_register(REG_STILL_AFTER, 24'($urandom_range(24'hFFFFFF)));
        write_register(REG_EMPTY_TIMEOUT, 24'($urandom_range(24'hFFFFFF)));
        write_register(REG_SAMPLE_PERIOD, 24'($urandom_range(24'hFFFFFF)));
        write_register(REG_UNMAPPED, 24'($urandom_range(24'hFFFFFF, 1)));
        @(posedge aclk);
        queue_visits(240);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("room_occupancy_state_machine_unit regression: pass");
        end else begin
            $display("room_occupancy_state_machine_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("room_occupancy_state_machine_unit regression: fail");
        $finish;
    end

endmodule
